// ===== rtl/tmbc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tmbc_pkg
// Shared types and constants of the tile map box collision core: field
// layout of the stream beats, register indexes and controller interface.
// ----------------------------------------------------------------------------
package tmbc_pkg;

    // Tile geometry: the tile size must be a power of two.
    localparam int unsigned TILE_PIXELS = 32;
    localparam int unsigned TILE_SHIFT  = $clog2(TILE_PIXELS);
    localparam int unsigned NEAR_LIMIT  = TILE_PIXELS - 2;
    localparam int unsigned EDGE_GAP    = 2;

    localparam int unsigned DEF_MAX_COLUMNS = 64;
    localparam int unsigned DEF_MAX_ROWS    = 64;

    // Widths
    localparam int unsigned COORD_W   = 16;
    localparam int unsigned MARGIN_W  = 11;
    localparam int unsigned SIZE_W    = 7;
    localparam int unsigned CELL_W    = 6;
    localparam int unsigned CODE_W    = 8;
    localparam int unsigned SUM_W     = 18;
    localparam int unsigned CNT_W     = 11;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 11;

    // Input tdata layout, lowest bit first
    localparam int unsigned IN_TDATA_W  = 88;
    localparam int unsigned POS_COL     = 0;
    localparam int unsigned POS_ROW     = 6;
    localparam int unsigned POS_CODE    = 12;
    localparam int unsigned POS_PX      = 20;
    localparam int unsigned POS_PY      = 36;
    localparam int unsigned POS_SX      = 52;
    localparam int unsigned POS_SY      = 68;
    localparam int unsigned POS_LEFT    = 84;
    localparam int unsigned POS_RIGHT   = 85;
    localparam int unsigned POS_UP      = 86;
    localparam int unsigned POS_DOWN    = 87;
    localparam int unsigned OUT_TDATA_W = 8;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;
    localparam logic [CODE_W-1:0] SOLID_CODE = 8'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP_COLUMNS   = 2'd0,
        CFG_MAP_ROWS      = 2'd1,
        CFG_LEFT_MARGIN   = 2'd2,
        CFG_BOTTOM_MARGIN = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic capture;
        logic clear_en;
        logic mem_write;
        logic calc;
        logic load_out;
    } tmbc_cmd_t;

    typedef struct packed {
        logic clear_last;
    } tmbc_status_t;

endpackage
`default_nettype wire

// ===== rtl/tmbc_bank_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tmbc_bank_ram
// One bank of the solid map: single write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module tmbc_bank_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic          wdata,
    input  wire logic [AW-1:0] raddr,
    output logic               rdata
);

    logic mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/tmbc_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tmbc_datapath
// Configuration registers, item capture, tile index and bound checks,
// four parity-banked map stores and the result register.
// ----------------------------------------------------------------------------
module tmbc_datapath #(
    parameter int unsigned MAX_COLUMNS = tmbc_pkg::DEF_MAX_COLUMNS,
    parameter int unsigned MAX_ROWS    = tmbc_pkg::DEF_MAX_ROWS
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_write,
    input  wire logic [tmbc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tmbc_pkg::CFG_DAT_W-1:0]      cfg_data,
    input  wire logic [tmbc_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  wire tmbc_pkg::tmbc_cmd_t                 cmd,
    output tmbc_pkg::tmbc_status_t                   status,
    output logic                                     hit,
    output logic                                     outside_map
);

    localparam int unsigned HALF_COLS  = (MAX_COLUMNS + 1) / 2;
    localparam int unsigned HALF_ROWS  = (MAX_ROWS + 1) / 2;
    localparam int unsigned BANK_DEPTH = HALF_COLS * HALF_ROWS;
    localparam int unsigned BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int unsigned COL_IW     = $clog2(MAX_COLUMNS);
    localparam int unsigned ROW_IW     = $clog2(MAX_ROWS);
    localparam int unsigned TS         = tmbc_pkg::TILE_SHIFT;
    localparam int unsigned SW         = tmbc_pkg::SUM_W;
    localparam int unsigned CW         = tmbc_pkg::CNT_W;

    function automatic logic [BANK_AW-1:0] bank_addr(input logic [31:0] row_half,
                                                     input logic [31:0] col_half);
        logic [31:0] a;
        a = row_half * HALF_COLS + col_half;
        return a[BANK_AW-1:0];
    endfunction

    // Configuration
    logic        [tmbc_pkg::SIZE_W-1:0]   map_columns_reg;
    logic        [tmbc_pkg::SIZE_W-1:0]   map_rows_reg;
    logic signed [tmbc_pkg::MARGIN_W-1:0] left_margin_reg;
    logic signed [tmbc_pkg::MARGIN_W-1:0] bottom_margin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_columns_reg   <= tmbc_pkg::SIZE_W'(64);
            map_rows_reg      <= tmbc_pkg::SIZE_W'(64);
            left_margin_reg   <= '0;
            bottom_margin_reg <= '0;
        end else if (cfg_write) begin
            unique case (tmbc_pkg::cfg_index_t'(cfg_index))
                tmbc_pkg::CFG_MAP_COLUMNS:   map_columns_reg   <= cfg_data[tmbc_pkg::SIZE_W-1:0];
                tmbc_pkg::CFG_MAP_ROWS:      map_rows_reg      <= cfg_data[tmbc_pkg::SIZE_W-1:0];
                tmbc_pkg::CFG_LEFT_MARGIN:   left_margin_reg   <= $signed(cfg_data);
                tmbc_pkg::CFG_BOTTOM_MARGIN: bottom_margin_reg <= $signed(cfg_data);
            endcase
        end
    end

    // Captured item
    logic        [tmbc_pkg::CELL_W-1:0]  col_reg;
    logic        [tmbc_pkg::CELL_W-1:0]  row_reg;
    logic        [tmbc_pkg::CODE_W-1:0]  code_reg;
    logic signed [tmbc_pkg::COORD_W-1:0] px_reg, py_reg, sx_reg, sy_reg;
    logic                                en_l_reg, en_r_reg, en_u_reg, en_d_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            col_reg  <= s_tdata[tmbc_pkg::POS_COL  +: tmbc_pkg::CELL_W];
            row_reg  <= s_tdata[tmbc_pkg::POS_ROW  +: tmbc_pkg::CELL_W];
            code_reg <= s_tdata[tmbc_pkg::POS_CODE +: tmbc_pkg::CODE_W];
            px_reg   <= $signed(s_tdata[tmbc_pkg::POS_PX +: tmbc_pkg::COORD_W]);
            py_reg   <= $signed(s_tdata[tmbc_pkg::POS_PY +: tmbc_pkg::COORD_W]);
            sx_reg   <= $signed(s_tdata[tmbc_pkg::POS_SX +: tmbc_pkg::COORD_W]);
            sy_reg   <= $signed(s_tdata[tmbc_pkg::POS_SY +: tmbc_pkg::COORD_W]);
            en_l_reg <= s_tdata[tmbc_pkg::POS_LEFT];
            en_r_reg <= s_tdata[tmbc_pkg::POS_RIGHT];
            en_u_reg <= s_tdata[tmbc_pkg::POS_UP];
            en_d_reg <= s_tdata[tmbc_pkg::POS_DOWN];
        end
    end

    // Tile index: arithmetic shift gives the floor; the low bits give the
    // offset of the box inside the tile.
    logic signed [SW-1:0] sum_x, sum_y, tx, ty;
    logic        [CW-1:0] cols_ext, rows_ext, cols_sat, rows_sat;
    logic                 out_x, out_y;

    always_comb begin
        sum_x    = SW'(sx_reg) + SW'(px_reg) - SW'(left_margin_reg);
        sum_y    = SW'(sy_reg) + SW'(py_reg) - SW'(bottom_margin_reg);
        tx       = sum_x >>> TS;
        ty       = sum_y >>> TS;
        cols_ext = CW'(map_columns_reg);
        rows_ext = CW'(map_rows_reg);
        cols_sat = (cols_ext > CW'(MAX_COLUMNS)) ? CW'(MAX_COLUMNS) : cols_ext;
        rows_sat = (rows_ext > CW'(MAX_ROWS))    ? CW'(MAX_ROWS)    : rows_ext;
        out_x    = tx[SW-1] || ((tx + SW'(2)) > $signed(SW'(cols_sat)));
        out_y    = ty[SW-1] || ((ty + SW'(2)) > $signed(SW'(rows_sat)));
    end

    logic [COL_IW-1:0] tx_reg;
    logic [ROW_IW-1:0] ty_reg;
    logic              outside_reg;
    logic              near_xl_reg, near_xr_reg, near_yt_reg, near_yb_reg;

    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            tx_reg      <= tx[COL_IW-1:0];
            ty_reg      <= ty[ROW_IW-1:0];
            outside_reg <= out_x || out_y;
            near_xl_reg <= sum_x[TS-1:0] < TS'(tmbc_pkg::NEAR_LIMIT);
            near_xr_reg <= sum_x[TS-1:0] > TS'(tmbc_pkg::EDGE_GAP);
            near_yt_reg <= sum_y[TS-1:0] < TS'(tmbc_pkg::NEAR_LIMIT);
            near_yb_reg <= sum_y[TS-1:0] > TS'(tmbc_pkg::EDGE_GAP);
        end
    end

    // Half indices: the even-parity neighbor sits at (t+1)/2, the odd at t/2
    logic [31:0] col_even, col_odd, row_even, row_odd;

    always_comb begin
        col_even = (32'(tx_reg) + 32'd1) >> 1;
        col_odd  = 32'(tx_reg) >> 1;
        row_even = (32'(ty_reg) + 32'd1) >> 1;
        row_odd  = 32'(ty_reg) >> 1;
    end

    // Clearing pass after reset
    logic [BANK_AW-1:0] clr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear_en) begin
            clr_cnt_reg <= clr_cnt_reg + BANK_AW'(1);
        end
    end

    assign status.clear_last = (clr_cnt_reg == BANK_AW'(BANK_DEPTH - 1));

    // Cell write
    logic               wr_ok;
    logic               wr_solid;
    logic [BANK_AW-1:0] wr_addr;

    always_comb begin
        wr_ok    = (32'(col_reg) < 32'(MAX_COLUMNS)) && (32'(row_reg) < 32'(MAX_ROWS));
        wr_solid = (code_reg == tmbc_pkg::SOLID_CODE);
        wr_addr  = bank_addr(32'(row_reg) >> 1, 32'(col_reg) >> 1);
    end

    // Bank b holds cells with row parity b[1] and column parity b[0]
    logic [3:0] rd_bit;

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic               we;
        logic [BANK_AW-1:0] waddr;
        logic               wdata;
        logic [BANK_AW-1:0] raddr;

        always_comb begin
            we    = cmd.clear_en || (cmd.mem_write && wr_ok &&
                    (row_reg[0] == b[1]) && (col_reg[0] == b[0]));
            waddr = cmd.clear_en ? clr_cnt_reg : wr_addr;
            wdata = cmd.clear_en ? 1'b0 : wr_solid;
            raddr = bank_addr(b[1] ? row_odd : row_even, b[0] ? col_odd : col_even);
        end

        tmbc_bank_ram #(
            .DEPTH (BANK_DEPTH),
            .AW    (BANK_AW)
        ) u_ram (
            .aclk  (aclk),
            .we    (we),
            .waddr (waddr),
            .wdata (wdata),
            .raddr (raddr),
            .rdata (rd_bit[b])
        );
    end

    // Map the four bank bits back onto the 2x2 tile square
    logic tile_tl, tile_tr, tile_bl, tile_br, hit_next;

    always_comb begin
        tile_tl  = rd_bit[{ty_reg[0],  tx_reg[0]}];
        tile_tr  = rd_bit[{ty_reg[0], ~tx_reg[0]}];
        tile_bl  = rd_bit[{~ty_reg[0],  tx_reg[0]}];
        tile_br  = rd_bit[{~ty_reg[0], ~tx_reg[0]}];
        hit_next = ((en_l_reg || en_u_reg) && tile_tl && near_xl_reg && near_yt_reg) ||
                   ((en_l_reg || en_d_reg) && tile_bl && near_xl_reg && near_yb_reg) ||
                   ((en_r_reg || en_u_reg) && tile_tr && near_xr_reg && near_yt_reg) ||
                   ((en_r_reg || en_d_reg) && tile_br && near_xr_reg && near_yb_reg);
    end

    logic hit_reg, outside_map_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            hit_reg         <= outside_reg || hit_next;
            outside_map_reg <= outside_reg;
        end
    end

    assign hit         = hit_reg;
    assign outside_map = outside_map_reg;

endmodule
`default_nettype wire

// ===== rtl/tmbc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tmbc_ctrl
// Controller: clearing pass, item acceptance, query sequencing and the
// valid flag of the result register.
// ----------------------------------------------------------------------------
module tmbc_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_opcode,
    output logic                        s_tready,
    input  wire logic                   m_tready,
    output logic                        m_tvalid,
    input  wire tmbc_pkg::tmbc_status_t status,
    output tmbc_pkg::tmbc_cmd_t         cmd
);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_WRITE = 6'b000100,
        ST_CALC  = 6'b001000,
        ST_READ  = 6'b010000,
        ST_EVAL  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_en = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = (s_opcode == tmbc_pkg::OP_QUERY) ? ST_CALC : ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.mem_write = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_CALC: begin
                cmd.calc   = 1'b1;
                state_next = ST_READ;
            end
            ST_READ: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                // hold until the result register is free
                if (!out_valid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule
`default_nettype wire

// ===== rtl/tile_map_box_collision_core.sv =====
`default_nettype none
// Queries: a result passes the calc, bank read and evaluate steps of the
//   controller and waits in evaluate while the result register holds a beat not
//   yet taken; a new query or cell write is taken only once the controller is idle.
// Reset: after aresetn the map is swept clear, one address of all four banks
//   per cycle, over all ceil(MAX_COLUMNS/2)*ceil(MAX_ROWS/2) addresses (1024 at
//   the defaults) with s_tready low; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// tile_map_box_collision_core
// Keeps a map of solid tiles and answers box-versus-map collision queries.
// ----------------------------------------------------------------------------
module tile_map_box_collision_core #(
    parameter int unsigned MAX_COLUMNS = tmbc_pkg::DEF_MAX_COLUMNS,
    parameter int unsigned MAX_ROWS    = tmbc_pkg::DEF_MAX_ROWS
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Configuration write channel
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [tmbc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [tmbc_pkg::CFG_DAT_W-1:0]   cfg_data,
    // Input items
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // cell_column[5:0], cell_row[11:6], cell_code[19:12], pos_x[35:20],
    // pos_y[51:36], scroll_x[67:52], scroll_y[83:68], test_left[84],
    // test_right[85], test_up[86], test_down[87]
    input  wire logic [tmbc_pkg::IN_TDATA_W-1:0]  s_tdata,
    // opcode[0]
    input  wire logic [0:0]                       s_tuser,
    // Results
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // hit[0], outside_map[1], zeros[7:2]
    output logic [tmbc_pkg::OUT_TDATA_W-1:0]      m_tdata
);

    tmbc_pkg::tmbc_cmd_t    cmd;
    tmbc_pkg::tmbc_status_t status;
    logic                   hit;
    logic                   outside_map;

    assign cfg_ready = 1'b1;

    tmbc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_opcode (s_tuser[0]),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    tmbc_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tdata     (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .hit         (hit),
        .outside_map (outside_map)
    );

    assign m_tdata = {{(tmbc_pkg::OUT_TDATA_W - 2){1'b0}}, outside_map, hit};

    // No beat is taken while the map is being cleared
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_en |-> !s_tready)
        else $error("input beat offered ready during clearing pass");

    // A result outside the map always reports a hit
    a_outside_hits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> m_tdata[0])
        else $error("outside_map set without hit");

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("result register loaded over a pending beat");

    // The clearing pass and cell writes never share a cycle
    a_write_after_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mem_write |-> !cmd.clear_en && $past(cmd.capture))
        else $error("cell write outside its sequence");

endmodule
`default_nettype wire
